FILE: rtl/odr_pkg.sv
// Shared constants and types for the optical density pipeline.
`timescale 1ns / 1ps
package odr_pkg;

   localparam int unsigned RATIO_SCALE   = 10000;
   localparam int unsigned SCALE_BITS    = 14;
   localparam int unsigned Q_MAX         = 100000000;
   localparam int unsigned Q_BITS        = 27;
   localparam int unsigned LIMIT_BITS    = 27;
   localparam int unsigned N_BITS        = 5;
   localparam int unsigned MANT_BITS     = 30;
   localparam int unsigned LOG2_FRAC     = 28;
   localparam int unsigned LOG2_BITS     = 33;
   localparam int unsigned LOG10_2_BITS  = 31;
   localparam logic [30:0] LOG10_OF_2_Q32 = 31'd1292913986;
   localparam int unsigned OD_BITS       = 24;

   // Per-stage control that travels with each request.
   typedef struct packed {
      logic valid;
      logic floor;
      logic clamp;
   } ctl_type;

endpackage

FILE: rtl/odr_if.sv
// Request and result channel interfaces.
`timescale 1ns / 1ps
interface odr_req_if #(parameter int READING_BITS = 24);
   logic                    valid;
   logic                    ready;
   logic [READING_BITS-1:0] sample_level;
   logic [READING_BITS-1:0] reference_level;
   logic [READING_BITS-1:0] dark_level;
   modport source (output valid, sample_level, reference_level, dark_level, input ready);
   modport sink   (input valid, sample_level, reference_level, dark_level, output ready);
endinterface

interface odr_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [odr_pkg::OD_BITS-1:0]  od_value;
   logic                                below_floor;
   logic                                ratio_clamped;
   modport source (output valid, od_value, below_floor, ratio_clamped, input ready);
   modport sink   (input valid, od_value, below_floor, ratio_clamped, output ready);
endinterface

FILE: rtl/optical_density_from_readings_top.sv
// Top level: pipelined optical density (log10 of blank/sample ratio) per well.
//
// Usage notes
//   req_if  : one request per well: sample, reference (blank) and dark levels.
//   rsp_if  : one result per request, in order: od_value (Q.OD_FRACTION_BITS,
//             two's complement), below_floor, ratio_clamped.
//   A request is taken at a clock edge with valid and ready both high.
//   Throughput: one request per cycle unless the output stalls; no
//   dependence between wells. Pipeline: 3 setup stages, a
//   27-stage restoring divider (one quotient bit per stage), clamp and
//   two normalize stages, 28 squaring stages for log2 (one 31x31 multiply
//   each), then the log10 scale multiply and the rounding stage.
//   Backpressure: the whole pipe advances together; when a result sits in
//   the output register and rsp_if.ready is low, every stage holds and
//   req_if.ready drops, so nothing is lost or repeated.
//   Reset (synchronous, active high) clears all valid bits; data registers
//   are not reset. No configuration, no kept state between requests.
`timescale 1ns / 1ps
module optical_density_from_readings_top #(
   parameter int READING_BITS     = 24,
   parameter int OD_FRACTION_BITS = 20
) (
   input  logic clock,
   input  logic reset,
   odr_req_if.sink   req_if,
   odr_rsp_if.source rsp_if
);
   localparam int RB   = READING_BITS;
   localparam int FB   = OD_FRACTION_BITS;
   localparam int DW   = RB + odr_pkg::SCALE_BITS;   // span * 10000
   localparam int CW   = RB + odr_pkg::LIMIT_BITS;   // signal * (Q_MAX + 1)
   localparam int QB   = odr_pkg::Q_BITS;
   localparam int MB   = odr_pkg::MANT_BITS + 1;
   localparam int LF   = odr_pkg::LOG2_FRAC;
   localparam int NS   = 63;
   localparam int DIV0 = 2;                 // stage of divider entry
   localparam int CLMP = DIV0 + QB + 1;     // clamp stage
   localparam int NRM1 = CLMP + 1;
   localparam int LOG0 = NRM1 + 1;
   localparam int MULS = LOG0 + LF + 1;
   localparam int OUTS = MULS + 1;

   logic adv;
   odr_pkg::ctl_type ctl_ff [0:NS-1];
   odr_pkg::ctl_type ctl_in [0:NS-1];

   assign adv          = !ctl_ff[OUTS].valid || rsp_if.ready;
   assign req_if.ready = adv;

   // ---------------- stage 0: differences and floor check
   logic [RB:0]   span_d, sig_d;
   logic [RB-1:0] span_ff, sig_ff;
   assign span_d = {1'b0, req_if.reference_level} - {1'b0, req_if.dark_level};
   assign sig_d  = {1'b0, req_if.sample_level} - {1'b0, req_if.dark_level};
   always_comb begin
      ctl_in[0].valid = req_if.valid;
      ctl_in[0].floor = span_d[RB] || (span_d == '0) || sig_d[RB] || (sig_d == '0);
      ctl_in[0].clamp = 1'b0;
   end

   // ---------------- stage 1: scaled dividend and high-clamp limit
   logic [DW-1:0] dvd_ff;
   logic [CW-1:0] lim_ff;
   logic [RB-1:0] dvs1_ff;

   // ---------------- divider: stage DIV0 + j holds remainder after j bits
   logic [CW-1:0] rem_ff [0:QB];
   logic [QB-1:0] quo_ff [0:QB];
   logic [RB-1:0] dvs_ff [0:QB];
   logic [CW-1:0] rem_in [1:QB];
   logic [QB-1:0] quo_in [1:QB];

   always_comb begin
      ctl_in[1] = ctl_ff[0];
      ctl_in[DIV0] = ctl_ff[1];
      ctl_in[DIV0].clamp = ({{(CW-DW){1'b0}}, dvd_ff} >= lim_ff);
   end

   for (genvar j = 1; j <= QB; j++) begin : g_div
      localparam int K = QB - j;
      logic [CW-1:0] sh;
      assign sh = {{(CW-RB){1'b0}}, dvs_ff[j-1]} << K;
      always_comb begin
         ctl_in[DIV0+j] = ctl_ff[DIV0+j-1];
         if (rem_ff[j-1] >= sh) begin
            rem_in[j] = rem_ff[j-1] - sh;
            quo_in[j] = quo_ff[j-1] | (QB'(1) << K);
         end else begin
            rem_in[j] = rem_ff[j-1];
            quo_in[j] = quo_ff[j-1];
         end
      end
   end

   // ---------------- clamp
   logic [QB-1:0] q_ff;
   logic [QB-1:0] q_in;
   always_comb begin
      ctl_in[CLMP] = ctl_ff[CLMP-1];
      q_in = quo_ff[QB];
      if (ctl_ff[CLMP-1].clamp) begin
         q_in = QB'(odr_pkg::Q_MAX);
      end else if (quo_ff[QB] == '0) begin
         q_in = QB'(1);
         ctl_in[CLMP].clamp = 1'b1;
      end
   end

   // ---------------- normalize: leading one search, then shift
   logic [odr_pkg::N_BITS-1:0] n_in;
   logic [odr_pkg::N_BITS-1:0] n1_ff;
   logic [QB-1:0]              q1_ff;
   always_comb begin
      ctl_in[NRM1] = ctl_ff[CLMP];
      n_in = '0;
      for (int b = 0; b < QB; b++) begin
         if (q_ff[b]) n_in = odr_pkg::N_BITS'(b);
      end
   end

   logic [MB-1:0]              m_ff [0:LF];
   logic [MB-1:0]              m_in [1:LF];
   logic [LF-1:0]              fr_ff [0:LF];
   logic [LF-1:0]              fr_in [1:LF];
   logic [odr_pkg::N_BITS-1:0] n_ff [0:LF];
   logic [MB-1:0]              m0_in;
   assign m0_in = {{(MB-QB){1'b0}}, q1_ff} << (5'(odr_pkg::MANT_BITS) - n1_ff);
   assign ctl_in[LOG0] = ctl_ff[NRM1];

   // ---------------- log2 by repeated squaring, one fraction bit per stage
   for (genvar j = 1; j <= LF; j++) begin : g_log
      logic [2*MB-1:0] p;
      logic [MB:0]     sq;
      assign p  = m_ff[j-1] * m_ff[j-1];
      assign sq = p[odr_pkg::MANT_BITS +: MB+1];
      always_comb begin
         ctl_in[LOG0+j] = ctl_ff[LOG0+j-1];
         if (sq[MB]) begin
            m_in[j]  = sq[MB:1];
            fr_in[j] = fr_ff[j-1] | (LF'(1) << (LF - j));
         end else begin
            m_in[j]  = sq[MB-1:0];
            fr_in[j] = fr_ff[j-1];
         end
      end
   end

   // ---------------- log10 scale and rounding
   logic [63:0] l10_ff;
   logic [63:0] l10_in;
   logic [63:0] rnd;
   logic [63:0] od_full;
   logic [odr_pkg::OD_BITS-1:0] od_in, od_ff;
   assign l10_in = 64'({n_ff[LF], fr_ff[LF]}) * 64'(odr_pkg::LOG10_OF_2_Q32);
   assign ctl_in[MULS] = ctl_ff[MULS-1];
   assign rnd     = (l10_ff + (64'd1 << (59 - FB))) >> (60 - FB);
   assign od_full = rnd - (64'd4 << FB);
   always_comb begin
      ctl_in[OUTS] = ctl_ff[MULS];
      od_in = ctl_ff[MULS].floor ? '0 : od_full[odr_pkg::OD_BITS-1:0];
      if (ctl_ff[MULS].floor) ctl_in[OUTS].clamp = 1'b0;
   end

   // ---------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NS; s++) ctl_ff[s] <= '0;
      end else if (adv) begin
         for (int s = 0; s < NS; s++) ctl_ff[s] <= ctl_in[s];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         span_ff  <= span_d[RB-1:0];
         sig_ff   <= sig_d[RB-1:0];
         dvd_ff   <= DW'(span_ff) * DW'(odr_pkg::RATIO_SCALE);
         lim_ff   <= CW'(sig_ff) * CW'(odr_pkg::Q_MAX + 1);
         dvs1_ff  <= sig_ff;
         rem_ff[0] <= {{(CW-DW){1'b0}}, dvd_ff};
         quo_ff[0] <= '0;
         dvs_ff[0] <= dvs1_ff;
         for (int j = 1; j <= QB; j++) begin
            rem_ff[j] <= rem_in[j];
            quo_ff[j] <= quo_in[j];
            dvs_ff[j] <= dvs_ff[j-1];
         end
         q_ff     <= q_in;
         q1_ff    <= q_ff;
         n1_ff    <= n_in;
         m_ff[0]  <= m0_in;
         fr_ff[0] <= '0;
         n_ff[0]  <= n1_ff;
         for (int j = 1; j <= LF; j++) begin
            m_ff[j]  <= m_in[j];
            fr_ff[j] <= fr_in[j];
            n_ff[j]  <= n_ff[j-1];
         end
         l10_ff <= l10_in;
         od_ff  <= od_in;
      end
   end

   assign rsp_if.valid         = ctl_ff[OUTS].valid;
   assign rsp_if.od_value      = od_ff;
   assign rsp_if.below_floor   = ctl_ff[OUTS].floor;
   assign rsp_if.ratio_clamped = ctl_ff[OUTS].clamp;

   // ---------------- assertions
   a_floor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.below_floor |-> rsp_if.od_value == '0 && !rsp_if.ratio_clamped)
      else $error("floored result not zero");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |=> rsp_if.valid && $stable(rsp_if.od_value))
      else $error("stalled result lost");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_if.valid |-> req_if.ready)
      else $error("pipe stalled with empty output");

endmodule
